// ----- hdl/grc_pkg.sv -----
// Shared types, widths and constants of the grid ray caster.
// Depends on nothing; imported by grc_div, grid_ray_cast_top and its testbench.
package grc_pkg;

    // Configuration register indexes
    localparam logic [2:0] REG_COLS   = 3'd0;
    localparam logic [2:0] REG_ROWS   = 3'd1;
    localparam logic [2:0] REG_CELL   = 3'd2;
    localparam logic [2:0] REG_CX     = 3'd3;
    localparam logic [2:0] REG_CY     = 3'd4;
    localparam logic [2:0] REG_RANGE  = 3'd5;
    localparam logic [2:0] REG_THRESH = 3'd6;

    // Item operations
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_RAY   = 1'b1;

    // Datapath widths
    localparam int PNT_W     = 34;  // world point plus ray offset
    localparam int NUM_W     = 37;  // cell index numerator 2*(p-c)+res
    localparam int DEN_W     = 22;  // divisor 2*res
    localparam int COORD_W   = 38;  // cell coordinates
    localparam int ERR_W     = 40;  // Bresenham error term
    localparam int AXIS_W    = 33;  // rotator x, y in Q2.30, z in 2^-32 turn
    localparam int MUL_W     = 34;  // shared multiplier operands
    localparam int PROD_W    = 2 * MUL_W;
    localparam int DD_W      = 13;  // per-axis cell distance at stop
    localparam int D2_W      = 26;  // squared cell distance
    localparam int SQ_STEPS  = (D2_W + 32) / 2;
    localparam int ROOT_W    = SQ_STEPS;
    localparam int REM_W     = ROOT_W + 3;
    localparam int ROT_STEPS = 16;

    localparam logic [22:0] RANGE_CAP = 23'd6553600;
    localparam logic signed [AXIS_W-1:0] CORDIC_K = 33'sd652032874;

    typedef enum logic [1:0] {
        KIND_OCC  = 2'd0,
        KIND_LEFT = 2'd1,
        KIND_MAX  = 2'd2
    } stop_kind_t;

    // Arctangent of 2^-i in units of 2^-32 turn
    function automatic logic [29:0] atan_step(input logic [3:0] i);
        logic [29:0] v;
        case (i)
            4'd0:    v = 30'h20000000;
            4'd1:    v = 30'h12E4051E;
            4'd2:    v = 30'h09FB385B;
            4'd3:    v = 30'h051111D4;
            4'd4:    v = 30'h028B0D43;
            4'd5:    v = 30'h0145D7E1;
            4'd6:    v = 30'h00A2F61E;
            4'd7:    v = 30'h00517C55;
            4'd8:    v = 30'h0028BE53;
            4'd9:    v = 30'h00145F2F;
            4'd10:   v = 30'h000A2F98;
            4'd11:   v = 30'h000517CC;
            4'd12:   v = 30'h00028BE6;
            4'd13:   v = 30'h000145F3;
            4'd14:   v = 30'h0000A2FA;
            default: v = 30'h0000517D;
        endcase
        return v;
    endfunction

endpackage

// ----- hdl/grc_div.sv -----
// Radix-2 restoring divider giving a floored signed quotient.
// Depends on grc_pkg for widths.
module grc_div (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    input  logic signed [grc_pkg::NUM_W-1:0]   num,
    input  logic        [grc_pkg::DEN_W-1:0]   den,
    output logic                               done,
    output logic signed [grc_pkg::NUM_W-1:0]   quo
);
    import grc_pkg::*;

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [NUM_W-1:0] mag_reg;
    logic [DEN_W-1:0] rem_reg;
    logic [DEN_W-1:0] den_reg;
    logic             neg_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             done_reg;
    logic [DEN_W:0]   trial;
    logic             fit;
    logic [NUM_W-1:0] qfix;

    // One quotient bit per cycle
    assign trial = {rem_reg, mag_reg[NUM_W-1]};
    assign fit   = (trial >= {1'b0, den_reg});

    // Control: count and done pulse
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= (cnt_reg == CNT_W'(1));
            if (start)
                cnt_reg <= CNT_W'(NUM_W);
            else if (cnt_reg != '0)
                cnt_reg <= cnt_reg - CNT_W'(1);
        end
    end

    // Datapath: load magnitude, then shift and subtract
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            neg_reg <= num[NUM_W-1];
            mag_reg <= num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
            rem_reg <= '0;
            den_reg <= den;
        end
        else if (cnt_reg != '0)
        begin
            rem_reg <= fit ? DEN_W'(trial - {1'b0, den_reg}) : DEN_W'(trial);
            mag_reg <= {mag_reg[NUM_W-2:0], fit};
        end
    end

    // Round toward minus infinity for negative numerators
    assign qfix = mag_reg + NUM_W'(rem_reg != '0);
    assign quo  = neg_reg ? -$signed(qfix) : $signed(mag_reg);
    assign done = done_reg;

endmodule

// ----- hdl/grid_ray_cast_top.sv -----
// Grid ray caster: occupancy store, sequencer and shared arithmetic.
// Depends on grc_pkg and grc_div.
//
//  channel | handshake           | payload
//  in      | in_valid / in_stall | op, cell_col, cell_row, cell_value,
//          |                     | start_x, start_y, heading
//  out     | out_valid/out_stall | distance, stop_kind
//  cfg     | cfg_valid/cfg_ready | cfg_index, cfg_data
//
// A write item is stored without stalling the input. A ray item first runs setup
// (16 rotator steps, four divisions, two multiplies), then walks the grid with
// one grid memory read per cell walked, then, unless it stopped at maximum range,
// takes the square root and scales. The walk probes each cell through the single memory read port.
// in_stall is high from ray acceptance until its result is in the output
// register; a waiting result does not block the next item.
// Reset clears control and loads the default configuration; the grid store is not cleared.
module grid_ray_cast_top #(
    parameter int MAX_COLS = 512,
    parameter int MAX_ROWS = 512
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic                op,
    input  logic [8:0]          cell_col,
    input  logic [8:0]          cell_row,
    input  logic signed [7:0]   cell_value,
    input  logic signed [31:0]  start_x,
    input  logic signed [31:0]  start_y,
    input  logic [15:0]         heading,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [22:0]         distance,
    output logic [1:0]          stop_kind,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [2:0]          cfg_index,
    input  logic [31:0]         cfg_data
);
    import grc_pkg::*;

    localparam int DEPTH  = MAX_COLS * MAX_ROWS;
    localparam int ADDR_W = $clog2(DEPTH);

    typedef enum logic [19:0] {
        S_IDLE   = 20'h00001,
        S_ROT    = 20'h00002,
        S_QUAD   = 20'h00004,
        S_MULX   = 20'h00008,
        S_MULY   = 20'h00010,
        S_ENDY   = 20'h00020,
        S_DIVLD  = 20'h00040,
        S_DIVWT  = 20'h00080,
        S_DELTA  = 20'h00100,
        S_ORIENT = 20'h00200,
        S_PROBE  = 20'h00400,
        S_EVAL   = 20'h00800,
        S_DIFF   = 20'h01000,
        S_SQX    = 20'h02000,
        S_SQY    = 20'h04000,
        S_SQSUM  = 20'h08000,
        S_ROOT   = 20'h10000,
        S_SCALE  = 20'h20000,
        S_ROUND  = 20'h40000,
        S_DONE   = 20'h80000
    } state_t;

    state_t state_reg, state_next;

    // Configuration registers
    logic [9:0]               grid_cols_reg, grid_rows_reg;
    logic [20:0]              cell_size_reg;
    logic signed [31:0]       centre_x_reg, centre_y_reg;
    logic [22:0]              max_range_reg;
    logic signed [7:0]        hit_thr_reg;

    // Ray working registers
    logic signed [31:0]       sx_reg, sy_reg;
    logic [15:0]              heading_reg;
    logic [9:0]               cols_reg, rows_reg;
    logic [20:0]              res_reg;
    logic [22:0]              mr_reg;
    logic signed [AXIS_W-1:0] cx_reg, cy_reg, cz_reg, co_reg, si_reg;
    logic [4:0]               step_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [PNT_W-1:0]  p1x_reg, p1y_reg;
    logic [1:0]               idx_reg;
    logic signed [COORD_W-1:0] x0_reg, y0_reg, x1_reg, y1_reg;
    logic [COORD_W-1:0]       adx_reg, ady_reg, dx_reg, dy_reg;
    logic                     steep_reg, x_up_reg, y_up_reg;
    logic signed [COORD_W-1:0] px_reg, py_reg, ox0_reg, oy0_reg, xend_reg;
    logic signed [ERR_W-1:0]  err_reg;
    stop_kind_t               kind_reg;
    logic [7:0]               rd_data_reg;
    logic [DD_W-1:0]          ddx_reg, ddy_reg;
    logic [D2_W-1:0]          d2_reg;
    logic [2*SQ_STEPS-1:0]    sqv_reg;
    logic [ROOT_W-1:0]        root_reg;
    logic [REM_W-1:0]         rem_reg;
    logic [22:0]              dist_reg;

    // Output register
    logic                     out_valid_reg;
    logic [22:0]              distance_reg;
    stop_kind_t               stop_kind_reg;

    logic [7:0]               grid_mem [DEPTH];

    logic                     in_accept, wr_en, rd_en, load_out;
    logic [ADDR_W-1:0]        wr_addr, rd_addr;

    // Combinational helpers
    logic signed [AXIS_W-1:0] sh_x, sh_y, atan_ext;
    logic signed [MUL_W-1:0]  mul_a, mul_b;
    logic signed [PROD_W-1:0] mul_prod, prod_rnd;
    logic signed [PNT_W-1:0]  p_sel, c_sel, p_end;
    logic signed [NUM_W-1:0]  diff_pc, div_num, div_quo;
    logic [DEN_W-1:0]         div_den;
    logic                     div_start, div_done;
    logic [9:0]               half_sel;
    logic signed [COORD_W-1:0] coord_new, d_x, d_y;
    logic signed [COORD_W-1:0] a0, a1, b0, b1, c_chk, r_chk, dd_a, dd_b;
    logic                     steep_now, in_grid, hit;
    logic signed [ERR_W-1:0]  err_sum;
    logic [REM_W-1:0]         rem_t, trial_sq;
    logic [PROD_W-1:0]        scaled;

    assign in_accept = in_valid && !in_stall;
    assign in_stall  = (state_reg != S_IDLE);
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign distance  = distance_reg;
    assign stop_kind = stop_kind_reg;
    assign load_out  = (state_reg == S_DONE) && (!out_valid_reg || !out_stall);

    // Grid store access
    assign wr_en   = in_accept && (op == OP_WRITE) && (32'(cell_col) < MAX_COLS)
                     && (32'(cell_row) < MAX_ROWS);
    assign wr_addr = ADDR_W'(cell_row) * ADDR_W'(MAX_COLS) + ADDR_W'(cell_col);
    assign c_chk   = steep_reg ? py_reg : px_reg;
    assign r_chk   = steep_reg ? px_reg : py_reg;
    assign in_grid = !c_chk[COORD_W-1] && !r_chk[COORD_W-1]
                     && (c_chk < $signed(COORD_W'(cols_reg)))
                     && (r_chk < $signed(COORD_W'(rows_reg)));
    assign rd_en   = (state_reg == S_PROBE) && in_grid;
    assign rd_addr = ADDR_W'(r_chk) * ADDR_W'(MAX_COLS) + ADDR_W'(c_chk);
    assign hit     = $signed(rd_data_reg) > hit_thr_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
            grid_mem[wr_addr] <= cell_value;
        if (rd_en)
            rd_data_reg <= grid_mem[rd_addr];
    end

    // Rotator step
    assign sh_x     = cx_reg >>> step_reg[3:0];
    assign sh_y     = cy_reg >>> step_reg[3:0];
    assign atan_ext = $signed(AXIS_W'(atan_step(step_reg[3:0])));

    // Shared multiplier operand select
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            S_MULX:
            begin
                mul_a = $signed(MUL_W'(mr_reg));
                mul_b = MUL_W'(co_reg);
            end
            S_MULY:
            begin
                mul_a = $signed(MUL_W'(mr_reg));
                mul_b = MUL_W'(si_reg);
            end
            S_SQX:
            begin
                mul_a = $signed(MUL_W'(ddx_reg));
                mul_b = $signed(MUL_W'(ddx_reg));
            end
            S_SQY:
            begin
                mul_a = $signed(MUL_W'(ddy_reg));
                mul_b = $signed(MUL_W'(ddy_reg));
            end
            S_SCALE:
            begin
                mul_a = $signed(MUL_W'(root_reg));
                mul_b = $signed(MUL_W'(res_reg));
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end
    assign mul_prod = mul_a * mul_b;

    // Ray end point: round offset half up from Q2.30
    assign prod_rnd = prod_reg + $signed(PROD_W'(32'h2000_0000));
    assign p_end    = PNT_W'(prod_rnd >>> 30);

    // Cell index division operands
    always_comb
    begin
        p_sel    = PNT_W'(sx_reg);
        c_sel    = PNT_W'(centre_x_reg);
        half_sel = cols_reg >> 1;
        case (idx_reg)
            2'd0:
            begin
                p_sel = PNT_W'(sx_reg);
                c_sel = PNT_W'(centre_x_reg);
                half_sel = cols_reg >> 1;
            end
            2'd1:
            begin
                p_sel = PNT_W'(sy_reg);
                c_sel = PNT_W'(centre_y_reg);
                half_sel = rows_reg >> 1;
            end
            2'd2:
            begin
                p_sel = p1x_reg;
                c_sel = PNT_W'(centre_x_reg);
                half_sel = cols_reg >> 1;
            end
            default:
            begin
                p_sel = p1y_reg;
                c_sel = PNT_W'(centre_y_reg);
                half_sel = rows_reg >> 1;
            end
        endcase
    end
    assign diff_pc   = NUM_W'(p_sel) - NUM_W'(c_sel);
    assign div_num   = (diff_pc <<< 1) + $signed(NUM_W'(res_reg));
    assign div_den   = {res_reg, 1'b0};
    assign div_start = (state_reg == S_DIVLD);
    assign coord_new = COORD_W'(div_quo) + $signed(COORD_W'(half_sel));

    grc_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quo   (div_quo)
    );

    // Orientation and walk helpers
    assign d_x       = x1_reg - x0_reg;
    assign d_y       = y1_reg - y0_reg;
    assign steep_now = ady_reg > adx_reg;
    assign a0        = steep_now ? y0_reg : x0_reg;
    assign a1        = steep_now ? y1_reg : x1_reg;
    assign b0        = steep_now ? x0_reg : y0_reg;
    assign b1        = steep_now ? x1_reg : y1_reg;
    assign err_sum   = err_reg + $signed(ERR_W'(dy_reg));
    assign dd_a      = px_reg - ox0_reg;
    assign dd_b      = py_reg - oy0_reg;

    // Square root digit step
    assign rem_t    = {rem_reg[REM_W-3:0], sqv_reg[2*SQ_STEPS-1 -: 2]};
    assign trial_sq = REM_W'({root_reg, 2'b01});
    assign scaled   = PROD_W'(prod_reg + $signed(PROD_W'(32'h8000))) >> 16;

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:   if (in_accept && op == OP_RAY) state_next = S_ROT;
            S_ROT:    if (step_reg == 5'(ROT_STEPS - 1)) state_next = S_QUAD;
            S_QUAD:   state_next = S_MULX;
            S_MULX:   state_next = S_MULY;
            S_MULY:   state_next = S_ENDY;
            S_ENDY:   state_next = S_DIVLD;
            S_DIVLD:  state_next = S_DIVWT;
            S_DIVWT:
                if (div_done)
                    state_next = (idx_reg == 2'd3) ? S_DELTA : S_DIVLD;
            S_DELTA:  state_next = S_ORIENT;
            S_ORIENT: state_next = S_PROBE;
            S_PROBE:  state_next = in_grid ? S_EVAL : S_DIFF;
            S_EVAL:
                if (hit)
                    state_next = S_DIFF;
                else if (px_reg == xend_reg)
                    state_next = S_DONE;
                else
                    state_next = S_PROBE;
            S_DIFF:   state_next = S_SQX;
            S_SQX:    state_next = S_SQY;
            S_SQY:    state_next = S_SQSUM;
            S_SQSUM:  state_next = S_ROOT;
            S_ROOT:   if (step_reg == 5'(SQ_STEPS - 1)) state_next = S_SCALE;
            S_SCALE:  state_next = S_ROUND;
            S_ROUND:  state_next = S_DONE;
            S_DONE:   if (load_out) state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    // Control state, output valid and configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            grid_cols_reg <= 10'd512;
            grid_rows_reg <= 10'd512;
            cell_size_reg <= 21'd3277;
            centre_x_reg  <= '0;
            centre_y_reg  <= '0;
            max_range_reg <= 23'd1966080;
            hit_thr_reg   <= -8'sd1;
        end
        else
        begin
            state_reg <= state_next;
            if (load_out)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    REG_COLS:   grid_cols_reg <= cfg_data[9:0];
                    REG_ROWS:   grid_rows_reg <= cfg_data[9:0];
                    REG_CELL:   cell_size_reg <= cfg_data[20:0];
                    REG_CX:     centre_x_reg  <= $signed(cfg_data);
                    REG_CY:     centre_y_reg  <= $signed(cfg_data);
                    REG_RANGE:  max_range_reg <= cfg_data[22:0];
                    REG_THRESH: hit_thr_reg   <= $signed(cfg_data[7:0]);
                    default:    ;
                endcase
            end
        end
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        prod_reg <= mul_prod;
        if (load_out)
        begin
            distance_reg  <= dist_reg;
            stop_kind_reg <= kind_reg;
        end
        unique case (state_reg)
            S_IDLE:
            begin
                // Latch the ray and clamp the configuration
                sx_reg      <= start_x;
                sy_reg      <= start_y;
                heading_reg <= heading;
                cols_reg    <= (32'(grid_cols_reg) > MAX_COLS) ? 10'(MAX_COLS)
                                                               : grid_cols_reg;
                rows_reg    <= (32'(grid_rows_reg) > MAX_ROWS) ? 10'(MAX_ROWS)
                                                               : grid_rows_reg;
                res_reg     <= (cell_size_reg == '0) ? 21'd1 : cell_size_reg;
                mr_reg      <= (max_range_reg > RANGE_CAP) ? RANGE_CAP : max_range_reg;
                cx_reg      <= CORDIC_K;
                cy_reg      <= '0;
                cz_reg      <= $signed(AXIS_W'({heading[13:0], 16'h0000}));
                step_reg    <= '0;
            end
            S_ROT:
            begin
                // Rotate toward zero residual angle
                if (!cz_reg[AXIS_W-1])
                begin
                    cx_reg <= cx_reg - sh_y;
                    cy_reg <= cy_reg + sh_x;
                    cz_reg <= cz_reg - atan_ext;
                end
                else
                begin
                    cx_reg <= cx_reg + sh_y;
                    cy_reg <= cy_reg - sh_x;
                    cz_reg <= cz_reg + atan_ext;
                end
                step_reg <= step_reg + 5'd1;
            end
            S_QUAD:
            begin
                // Map the first-quadrant result to the heading's quadrant
                case (heading_reg[15:14])
                    2'd0:
                    begin
                        co_reg <= cx_reg;
                        si_reg <= cy_reg;
                    end
                    2'd1:
                    begin
                        co_reg <= -cy_reg;
                        si_reg <= cx_reg;
                    end
                    2'd2:
                    begin
                        co_reg <= -cx_reg;
                        si_reg <= -cy_reg;
                    end
                    default:
                    begin
                        co_reg <= cy_reg;
                        si_reg <= -cx_reg;
                    end
                endcase
            end
            S_MULY:
                p1x_reg <= PNT_W'(sx_reg) + p_end;
            S_ENDY:
            begin
                p1y_reg <= PNT_W'(sy_reg) + p_end;
                idx_reg <= 2'd0;
            end
            S_DIVWT:
            begin
                if (div_done)
                begin
                    case (idx_reg)
                        2'd0:    x0_reg <= coord_new;
                        2'd1:    y0_reg <= coord_new;
                        2'd2:    x1_reg <= coord_new;
                        default: y1_reg <= coord_new;
                    endcase
                    idx_reg <= idx_reg + 2'd1;
                end
            end
            S_DELTA:
            begin
                adx_reg <= d_x[COORD_W-1] ? COORD_W'(-d_x) : COORD_W'(d_x);
                ady_reg <= d_y[COORD_W-1] ? COORD_W'(-d_y) : COORD_W'(d_y);
            end
            S_ORIENT:
            begin
                // Swap axes for steep lines and set up the walk
                steep_reg <= steep_now;
                x_up_reg  <= a0 < a1;
                y_up_reg  <= b0 < b1;
                xend_reg  <= (a0 < a1) ? a1 + COORD_W'(1) : a1 - COORD_W'(1);
                dx_reg    <= steep_now ? ady_reg : adx_reg;
                dy_reg    <= steep_now ? adx_reg : ady_reg;
                px_reg    <= a0;
                py_reg    <= b0;
                ox0_reg   <= a0;
                oy0_reg   <= b0;
                err_reg   <= '0;
            end
            S_PROBE:
                if (!in_grid)
                    kind_reg <= KIND_LEFT;
            S_EVAL:
            begin
                if (hit)
                    kind_reg <= KIND_OCC;
                else if (px_reg == xend_reg)
                begin
                    kind_reg <= KIND_MAX;
                    dist_reg <= mr_reg;
                end
                else
                begin
                    // Advance one cell along the major axis
                    px_reg <= x_up_reg ? px_reg + COORD_W'(1) : px_reg - COORD_W'(1);
                    if ($signed({err_sum, 1'b0}) >= $signed((ERR_W + 1)'(dx_reg)))
                    begin
                        py_reg  <= y_up_reg ? py_reg + COORD_W'(1) : py_reg - COORD_W'(1);
                        err_reg <= err_sum - $signed(ERR_W'(dx_reg));
                    end
                    else
                        err_reg <= err_sum;
                end
            end
            S_DIFF:
            begin
                ddx_reg <= dd_a[COORD_W-1] ? DD_W'(-dd_a) : DD_W'(dd_a);
                ddy_reg <= dd_b[COORD_W-1] ? DD_W'(-dd_b) : DD_W'(dd_b);
            end
            S_SQY:
                d2_reg <= D2_W'(prod_reg);
            S_SQSUM:
            begin
                sqv_reg  <= {D2_W'(d2_reg + D2_W'(prod_reg)), 32'h0};
                root_reg <= '0;
                rem_reg  <= '0;
                step_reg <= '0;
            end
            S_ROOT:
            begin
                // One root bit per cycle
                if (rem_t >= trial_sq)
                begin
                    rem_reg  <= rem_t - trial_sq;
                    root_reg <= {root_reg[ROOT_W-2:0], 1'b1};
                end
                else
                begin
                    rem_reg  <= rem_t;
                    root_reg <= {root_reg[ROOT_W-2:0], 1'b0};
                end
                sqv_reg  <= {sqv_reg[2*SQ_STEPS-3:0], 2'b00};
                step_reg <= step_reg + 5'd1;
            end
            S_ROUND:
                dist_reg <= (scaled > PROD_W'(RANGE_CAP)) ? RANGE_CAP : scaled[22:0];
            default:
                ;
        endcase
    end

`ifndef SYNTH
    a_div_only_waiting: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == S_DIVWT))
        else $error("divider finished outside its wait state");

    a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_DONE))
        else $error("result shown without finishing a ray");

    a_dist_capped: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (distance_reg <= RANGE_CAP))
        else $error("distance above range cap");

    a_eval_after_probe: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EVAL) |-> $past(state_reg == S_PROBE && in_grid))
        else $error("cell evaluated without an in-grid read");
`endif

endmodule

// ----- sim/grid_ray_cast_top_test.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for grid_ray_cast_top: fills the occupancy grid, casts rays
// under several register settings and compares each range with its own predictor.
// Depends on grc_pkg and the grid_ray_cast_top RTL.

typedef struct {
    logic [22:0] range_val;
    logic [1:0]  kind;
} range_rec_t;

// Scoreboard: hold predicted ranges in order and compare arriving results
class range_board;
    range_rec_t want_q[$];
    int         mismatches;
    int         matched;

    function void note_ray(range_rec_t r);
        want_q.push_back(r);
    endfunction

    function void check_result(logic [22:0] range_got, logic [1:0] kind);
        range_rec_t w;
        if (want_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
                $display("unexpected result: distance %0d kind %0d", range_got, kind);
            return;
        end
        w = want_q.pop_front();
        if (w.range_val !== range_got || w.kind !== kind) begin
            mismatches++;
            if (mismatches <= 10)
                $display("range mismatch: expected %0d/%0d, got %0d/%0d",
                         w.range_val, w.kind, range_got, kind);
        end else begin
            matched++;
        end
    endfunction

    function int pending();
        return want_q.size();
    endfunction
endclass

module grid_ray_cast_top_test;
    import grc_pkg::*;

    localparam int  NCOLS     = 512;
    localparam int  NROWS     = 512;
    localparam longint LIMIT  = 6000000;
    localparam longint CAP    = 6553600;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    logic               op;
    logic [8:0]         cell_col;
    logic [8:0]         cell_row;
    logic signed [7:0]  cell_value;
    logic signed [31:0] start_x;
    logic signed [31:0] start_y;
    logic [15:0]        heading;
    logic               out_valid;
    logic               out_stall;
    logic [22:0]        distance;
    logic [1:0]         stop_kind;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [2:0]         cfg_index;
    logic [31:0]        cfg_data;

    grid_ray_cast_top #(.MAX_COLS(NCOLS), .MAX_ROWS(NROWS)) i_dut (.*);

    range_board board = new;

    // Predictor state
    byte    occ[NCOLS*NROWS];
    bit     seen[NCOLS*NROWS];
    int     hot_q[$];
    longint p_cols, p_rows, p_cell, p_cx, p_cy, p_range, p_thresh;

    longint cycles;
    bit     hold_req;
    bit     no_idle;
    int     rays_sent;
    int     writes_sent;
    int     stop_counts[3];

    const longint ATAN[16] = '{
        64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4,
        64'h028B0D43, 64'h0145D7E1, 64'h00A2F61E, 64'h00517C55,
        64'h0028BE53, 64'h00145F2F, 64'h000A2F98, 64'h000517CC,
        64'h00028BE6, 64'h000145F3, 64'h0000A2FA, 64'h0000517D
    };

    // Clock and cycle limit
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("** grid_ray_cast_top: FAILED **");
            $finish;
        end
    end

    function automatic longint floor_div(longint n, longint d);
        if (n >= 0)
            return n / d;
        return -((-n + d - 1) / d);
    endfunction

    function automatic longint cell_of(longint p, longint c, longint res, longint half);
        return floor_div(2 * (p - c) + res, 2 * res) + half;
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v)
            b >>= 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    // Rotate to get cos/sin of heading in Q2.30
    function automatic void heading_trig(logic [15:0] h, output longint co, output longint si);
        longint x, y, z, nx, ny;
        x = 652032874;
        y = 0;
        z = longint'(h[13:0]) << 16;
        for (int i = 0; i < 16; i++) begin
            if (z >= 0) begin
                nx = x - (y >>> i);
                ny = y + (x >>> i);
                z -= ATAN[i];
            end else begin
                nx = x + (y >>> i);
                ny = y - (x >>> i);
                z += ATAN[i];
            end
            x = nx;
            y = ny;
        end
        case (h[15:14])
            2'd0: begin co = x;  si = y;  end
            2'd1: begin co = -y; si = x;  end
            2'd2: begin co = -x; si = -y; end
            default: begin co = y; si = -x; end
        endcase
    endfunction

    // -1 passes; otherwise the stop kind. Flag reads of never-written cells.
    function automatic int probe(longint c, longint r, longint cols, longint rows,
                                 inout bit blind);
        int idx;
        if (c < 0 || c >= cols || r < 0 || r >= rows)
            return int'(KIND_LEFT);
        idx = int'(r) * NCOLS + int'(c);
        if (!seen[idx])
            blind = 1'b1;
        return (longint'(occ[idx]) > p_thresh) ? int'(KIND_OCC) : -1;
    endfunction

    // Walk the ray; blind is set when the walk would touch an unwritten cell
    function automatic range_rec_t cast_ray(logic signed [31:0] sx, logic signed [31:0] sy,
                                            logic [15:0] h, output bit blind);
        longint cols, rows, res, mr, co, si;
        longint x0, y0, x1, y1, x, y, t, dx, dy, err, xs, ys, ddx, ddy;
        longint unsigned root, d;
        bit steep;
        int kind;
        range_rec_t rr;
        blind = 1'b0;
        cols = (p_cols > NCOLS) ? NCOLS : p_cols;
        rows = (p_rows > NROWS) ? NROWS : p_rows;
        res  = (p_cell == 0) ? 1 : p_cell;
        mr   = (p_range > CAP) ? CAP : p_range;
        heading_trig(h, co, si);
        x0 = cell_of(longint'(sx), p_cx, res, cols / 2);
        y0 = cell_of(longint'(sy), p_cy, res, rows / 2);
        x1 = cell_of(longint'(sx) + ((mr * co + (64'sd1 <<< 29)) >>> 30), p_cx, res, cols / 2);
        y1 = cell_of(longint'(sy) + ((mr * si + (64'sd1 <<< 29)) >>> 30), p_cy, res, rows / 2);
        steep = ((y1 > y0) ? y1 - y0 : y0 - y1) > ((x1 > x0) ? x1 - x0 : x0 - x1);
        if (steep) begin
            t = x0; x0 = y0; y0 = t;
            t = x1; x1 = y1; y1 = t;
        end
        dx = (x1 > x0) ? x1 - x0 : x0 - x1;
        dy = (y1 > y0) ? y1 - y0 : y0 - y1;
        xs = (x0 < x1) ? 1 : -1;
        ys = (y0 < y1) ? 1 : -1;
        err = 0;
        x = x0;
        y = y0;
        kind = steep ? probe(y, x, cols, rows, blind) : probe(x, y, cols, rows, blind);
        while (kind < 0 && x != x1 + xs && !blind) begin
            x += xs;
            err += dy;
            if (2 * err >= dx) begin
                y += ys;
                err -= dx;
            end
            kind = steep ? probe(y, x, cols, rows, blind) : probe(x, y, cols, rows, blind);
        end
        if (kind < 0) begin
            rr.range_val = mr[22:0];
            rr.kind = KIND_MAX;
        end else begin
            ddx = (x > x0) ? x - x0 : x0 - x;
            ddy = (y > y0) ? y - y0 : y0 - y;
            root = int_sqrt(longint'(ddx * ddx + ddy * ddy) << 32);
            d = (root * longint'(res) + 64'h8000) >> 16;
            rr.range_val = (d > CAP) ? CAP[22:0] : d[22:0];
            rr.kind = kind[1:0];
        end
        return rr;
    endfunction

    function automatic int rand_gap();
        int r;
        if (no_idle)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // Offer one item and hold it until accepted
    task automatic offer(logic o, logic [8:0] c, logic [8:0] r, logic signed [7:0] v,
                         logic signed [31:0] sx, logic signed [31:0] sy, logic [15:0] h);
        int g;
        @(negedge clk);
        op = o;
        cell_col = c;
        cell_row = r;
        cell_value = v;
        start_x = sx;
        start_y = sy;
        heading = h;
        in_valid = 1'b1;
        do
            @(posedge clk);
        while (in_stall);
        g = rand_gap();
        if (g > 0) begin
            @(negedge clk);
            in_valid = 1'b0;
            repeat (g - 1) @(negedge clk);
        end
    endtask

    task automatic write_cell(int c, int r, logic signed [7:0] v);
        int idx;
        idx = r * NCOLS + c;
        occ[idx] = v;
        if (!seen[idx])
            hot_q.push_back(idx);
        seen[idx] = 1'b1;
        writes_sent++;
        offer(OP_WRITE, c[8:0], r[8:0], v, $urandom, $urandom, $urandom);
    endtask

    // Cast only rays whose walk stays on written cells; returns whether sent
    task automatic try_ray(logic signed [31:0] sx, logic signed [31:0] sy, logic [15:0] h,
                           output bit sent);
        range_rec_t rr;
        bit blind;
        rr = cast_ray(sx, sy, h, blind);
        sent = !blind;
        if (!sent)
            return;
        offer(OP_RAY, $urandom, $urandom, $urandom, sx, sy, h);
        board.note_ray(rr);
        rays_sent++;
        stop_counts[rr.kind]++;
    endtask

    // Random world coordinate within a given cell
    function automatic logic signed [31:0] world_of(longint cellidx, longint half, longint ctr);
        longint res, j;
        res = (p_cell == 0) ? 1 : p_cell;
        j = longint'($urandom_range(0, 2 * 1048576)) % res - res / 2;
        return 32'(ctr + (cellidx - half) * res + j);
    endfunction

    task automatic random_ray(output bit sent);
        longint cols, rows, c, r;
        logic signed [31:0] sx, sy;
        int pick;
        cols = (p_cols > NCOLS) ? NCOLS : p_cols;
        rows = (p_rows > NROWS) ? NROWS : p_rows;
        pick = $urandom_range(0, 99);
        if (pick < 8) begin
            sx = $urandom;
            sy = $urandom;
        end else begin
            if (cols * rows > 4096 && hot_q.size() > 0 && pick < 75) begin
                r = hot_q[$urandom_range(0, hot_q.size() - 1)];
                c = r % NCOLS;
                r = r / NCOLS;
            end else begin
                c = longint'($urandom_range(0, cols + 3)) - 2;
                r = longint'($urandom_range(0, rows + 3)) - 2;
            end
            sx = world_of(c, cols / 2, p_cx);
            sy = world_of(r, rows / 2, p_cy);
        end
        try_ray(sx, sy, $urandom, sent);
    endtask

    // Drop the input, wait until all ranges are back and the block has gone quiet
    task automatic drain();
        @(negedge clk);
        in_valid = 1'b0;
        while (board.pending() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [31:0] val);
        @(negedge clk);
        cfg_index = idx;
        cfg_data = val;
        cfg_valid = 1'b1;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid = 1'b0;
        case (idx)
            REG_COLS:   p_cols = val & 32'h3FF;
            REG_ROWS:   p_rows = val & 32'h3FF;
            REG_CELL:   p_cell = val & 32'h1FFFFF;
            REG_CX:     p_cx = longint'(signed'(val));
            REG_CY:     p_cy = longint'(signed'(val));
            REG_RANGE:  p_range = val & 32'h7FFFFF;
            REG_THRESH: p_thresh = longint'(signed'(val[7:0]));
            default: ;
        endcase
    endtask

    task automatic setup(logic [31:0] cols, logic [31:0] rows, logic [31:0] csize,
                         logic [31:0] cx, logic [31:0] cy, logic [31:0] rng,
                         logic [31:0] thr);
        drain();
        write_reg(REG_COLS, cols);
        write_reg(REG_ROWS, rows);
        write_reg(REG_CELL, csize);
        write_reg(REG_CX, cx);
        write_reg(REG_CY, cy);
        write_reg(REG_RANGE, rng);
        write_reg(REG_THRESH, thr);
    endtask

    // Fill the grid area in use when it is small, then mix writes and rays
    task automatic run_phase(int n_items);
        longint cols, rows;
        bit sent;
        int tries;
        cols = (p_cols > NCOLS) ? NCOLS : p_cols;
        rows = (p_rows > NROWS) ? NROWS : p_rows;
        if (cols * rows <= 400)
            for (int r = 0; r < rows; r++)
                for (int c = 0; c < cols; c++)
                    write_cell(c, r, ($urandom_range(0, 3) == 0) ? $urandom : -8'sd128);
        for (int k = 0; k < n_items; k++) begin
            if ($urandom_range(0, 99) < 25 && cols * rows > 0) begin
                if (cols * rows > 4096)
                    write_cell($urandom_range(0, NCOLS - 1), $urandom_range(0, NROWS - 1),
                               $urandom);
                else
                    write_cell($urandom_range(0, cols - 1), $urandom_range(0, rows - 1),
                               ($urandom_range(0, 2) == 0) ? $urandom : -8'sd128);
            end else begin
                tries = 0;
                do begin
                    random_ray(sent);
                    tries++;
                end while (!sent && tries < 200);
            end
        end
    endtask

    // Receiver: random stalls plus one long hold-off on request
    always @(negedge clk)
    begin
        if (!rst_n) begin
            out_stall = 1'b0;
        end else if (hold_req) begin
            out_stall = 1'b1;
            repeat (4000) @(negedge clk);
            hold_req = 1'b0;
            out_stall = 1'b0;
        end else if (no_idle) begin
            out_stall = 1'b0;
        end else begin
            out_stall = ($urandom_range(0, 99) < 30) ||
                        ($urandom_range(0, 199) == 0 && out_stall);
        end
    end

    // Check each accepted result
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            board.check_result(distance, stop_kind);
    end

    initial
    begin
        bit sent;
        cycles = 0;
        hold_req = 1'b0;
        no_idle = 1'b0;
        rays_sent = 0;
        writes_sent = 0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        op = OP_WRITE;
        cell_col = '0;
        cell_row = '0;
        cell_value = '0;
        start_x = '0;
        start_y = '0;
        heading = '0;
        cfg_valid = 1'b0;
        cfg_index = REG_COLS;
        cfg_data = '0;
        p_cols = 512;
        p_rows = 512;
        p_cell = 3277;
        p_cx = 0;
        p_cy = 0;
        p_range = 1966080;
        p_thresh = -1;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: reset settings, corner cells, rays from the centre and far outside
        write_cell(0, 0, 8'sd127);
        write_cell(511, 511, -8'sd128);
        write_cell(511, 0, 8'sd0);
        write_cell(0, 511, 8'sd1);
        write_cell(256, 256, 8'sd5);
        write_cell(255, 256, -8'sd1);
        write_cell(257, 256, 8'sd0);
        try_ray(32'sd0, 32'sd0, 16'd0, sent);
        try_ray(32'sd0, 32'sd0, 16'd16384, sent);
        try_ray(32'sd0, 32'sd0, 16'd32768, sent);
        try_ray(32'sd0, 32'sd0, 16'd49152, sent);
        try_ray(32'sd0, 32'sd0, 16'hFFFF, sent);
        try_ray(32'h80000000, 32'sd0, 16'd0, sent);
        try_ray(32'sd0, 32'h7FFFFFFF, 16'd8192, sent);
        try_ray(32'h7FFFFFFF, 32'h80000000, 16'd40000, sent);
        try_ray(32'sd1638, 32'sd0, 16'd32768, sent);

        // Empty grid: every ray leaves at once
        setup(0, 0, 65536, 0, 0, 655360, 0);
        try_ray(32'sd0, 32'sd0, 16'd100, sent);
        try_ray(32'hFFFFFFFF, 32'sd1, 16'd60000, sent);

        // Small grid; long receiver hold-off while the sender keeps offering
        setup(8, 8, 65536, 32'h00012345, 32'hFFFE0000, 6553600, 0);
        hold_req = 1'b1;
        run_phase(40);

        // Single cell, unit cell size, zero range so every ray has zero length
        setup(1, 1, 1, 32'h80000000, 32'h7FFFFFFF, 0, 32'h7F);
        run_phase(20);

        // Oversized grid, zero cell size, range above the cap, lowest threshold
        setup(1023, 700, 0, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFF, 32'h80);
        run_phase(40);

        // Cell size of 2^20, zero range, highest threshold, no idling
        no_idle = 1'b1;
        setup(8, 6, 1048576, 32'hFFF00000, 32'h00100000, 0, 32'h7F);
        run_phase(30);
        no_idle = 1'b0;

        // Medium grid with mixed occupancy and a random range
        setup(12, 12, 20000, 32'h00030000, 32'h00050000, $urandom_range(0, 6553600), 0);
        run_phase(50);

        // Narrow strip, odd sizes
        setup(3, 17, 40000, 0, 0, 1000000, 32'hFF);
        run_phase(30);

        // Back to the full grid with reset-like settings
        setup(512, 512, 3277, 0, 0, 1966080, 32'hFF);
        run_phase(44);

        @(negedge clk);
        in_valid = 1'b0;
        drain();
        repeat (300) @(posedge clk);

        $display("cast %0d rays and stored %0d cells over 8 register settings;",
                 rays_sent, writes_sent);
        $display("stops: %0d occupied, %0d left grid, %0d max range, %0d ranges matched",
                 stop_counts[0], stop_counts[1], stop_counts[2], board.matched);
        if (board.mismatches == 0 && board.pending() == 0) begin
            $display("** grid_ray_cast_top: PASSED **");
        end else begin
            $display("%0d mismatches, %0d ranges still pending",
                     board.mismatches, board.pending());
            $display("** grid_ray_cast_top: FAILED **");
        end
        $finish;
    end

endmodule
